>>> design/gcci_pkg.sv
// Shared types and constants for the grid coordinate to crystal id translator.
`timescale 1ns / 1ps

package gcci_pkg;

    // Result field widths
    localparam int ID_W   = 31;
    localparam int PART_W = 3;
    localparam int ROW_W  = 11;
    localparam int COPY_W = 7;
    localparam int CRYS_W = 11;

    // Detector part (module number) codes
    typedef enum logic [PART_W-1:0] {
        PART_NONE       = 3'd0,
        PART_BARREL_A   = 3'd1,
        PART_BARREL_B   = 3'd2,
        PART_FWD_ENDCAP = 3'd3,
        PART_BWD_ENDCAP = 3'd4,
        PART_SHASHLYK   = 3'd5,
        PART_PROTO      = 3'd6
    } part_t;

    // Decimal packing weights
    localparam int WEIGHT_PART = 100000000;
    localparam int WEIGHT_ROW  = 1000000;
    localparam int WEIGHT_COPY = 10000;

    // Theta band limits
    localparam int BARREL_B_MAX  = 29;
    localparam int BARREL_A_END  = 73;
    localparam int FWD_LO        = 200;
    localparam int FWD_HI        = 300;
    localparam int FWD_SPLIT     = 250;
    localparam int BWD_HI        = 400;
    localparam int SHASH_HI      = 500;
    localparam int PROTO_HI      = 600;

    // Quadrant centers and offsets
    localparam int BWD_CENTER    = 350;
    localparam int SHASH_CENTER  = 450;
    localparam int PROTO_OFFSET  = 550;
    localparam int FWD_ROW_HI    = 212;
    localparam int FWD_ROW_LO    = 213;
    localparam int FWD_CRYS_LO   = 286;
    localparam int FWD_CRYS_HI   = 285;
    localparam int BARREL_B_ROW  = 30;
    localparam int BARREL_A_ROW  = 29;

    // Quadrant copy numbers
    localparam int QUAD_UP_HI    = 1;
    localparam int QUAD_UP_LO    = 2;
    localparam int QUAD_DN_LO    = 3;
    localparam int QUAD_DN_HI    = 4;

    // Divide by ten: q = (x * RECIP_MUL) >> RECIP_SHIFT, exact for x below 81920
    localparam int RECIP_W     = 16;
    localparam int RECIP_MUL   = 52429;
    localparam int RECIP_SHIFT = 19;
    localparam int BARREL_CRYS = 10;

endpackage

>>> design/gcci_decode.sv
// Band decode of (theta, phi) into detector part, row, copy and crystal.
`timescale 1ns / 1ps

module gcci_decode #(
    parameter int COORD_WIDTH = 10
) (
    input  logic [COORD_WIDTH-1:0]        theta,
    input  logic [COORD_WIDTH-1:0]        phi,
    output gcci_pkg::part_t               part,
    output logic signed [COORD_WIDTH+1:0] row,
    output logic [COORD_WIDTH-3:0]        copy,
    output logic signed [COORD_WIDTH+1:0] crys
);

    localparam int VAL_W  = COORD_WIDTH + 2;
    localparam int CPY_W  = COORD_WIDTH - 2;
    localparam int Q_W    = COORD_WIDTH - 3;
    localparam int PROD_W = COORD_WIDTH + gcci_pkg::RECIP_W;

    logic signed [VAL_W-1:0]  t_s;
    logic signed [VAL_W-1:0]  p_s;
    logic [COORD_WIDTH-1:0]   phi_m1;
    logic [PROD_W-1:0]        recip_prod;
    logic [Q_W-1:0]           quot;
    logic [COORD_WIDTH-1:0]   quot_x10;
    logic [3:0]               rem;
    logic [CPY_W-1:0]         barrel_copy;
    logic signed [VAL_W-1:0]  barrel_crys;
    logic signed [VAL_W-1:0]  center;
    logic signed [VAL_W-1:0]  quad_row;
    logic signed [VAL_W-1:0]  quad_crys;
    logic [CPY_W-1:0]         quad_copy;
    logic                     t_le_c;
    logic                     p_gt_c;

    assign t_s = $signed({2'b00, theta});
    assign p_s = $signed({2'b00, phi});

    // Barrel: (phi-1)/10 and (phi-1)%10 by reciprocal multiply
    assign phi_m1     = phi - COORD_WIDTH'(1);
    assign recip_prod = PROD_W'(phi_m1) * PROD_W'(gcci_pkg::RECIP_MUL);
    assign quot       = recip_prod[gcci_pkg::RECIP_SHIFT +: Q_W];
    assign quot_x10   = {quot, 3'b000} + COORD_WIDTH'({quot, 1'b0});
    assign rem        = phi_m1[3:0] - quot_x10[3:0];

    // Phi zero truncates toward zero: copy 1, crystal 11
    always_comb begin
        if (phi == '0) begin
            barrel_copy = CPY_W'(1);
            barrel_crys = VAL_W'(gcci_pkg::BARREL_CRYS + 1);
        end else begin
            barrel_copy = CPY_W'(quot) + CPY_W'(1);
            barrel_crys = VAL_W'(gcci_pkg::BARREL_CRYS) - VAL_W'(rem);
        end
    end

    // Quadrant scheme shared by backward endcap and shashlyk
    assign center = (theta < COORD_WIDTH'(gcci_pkg::BWD_HI)) ?
                    VAL_W'(gcci_pkg::BWD_CENTER) : VAL_W'(gcci_pkg::SHASH_CENTER);
    assign t_le_c = (t_s <= center);
    assign p_gt_c = (p_s > center);

    always_comb begin
        if (t_le_c) begin
            quad_row  = center + VAL_W'(1) - t_s;
            quad_copy = p_gt_c ? CPY_W'(gcci_pkg::QUAD_UP_HI) : CPY_W'(gcci_pkg::QUAD_UP_LO);
        end else begin
            quad_row  = t_s - center;
            quad_copy = p_gt_c ? CPY_W'(gcci_pkg::QUAD_DN_HI) : CPY_W'(gcci_pkg::QUAD_DN_LO);
        end
        quad_crys = p_gt_c ? (p_s - center) : (center + VAL_W'(1) - p_s);
    end

    // Band select
    always_comb begin
        part = gcci_pkg::PART_NONE;
        row  = '0;
        copy = '0;
        crys = '0;
        if (theta <= COORD_WIDTH'(gcci_pkg::BARREL_B_MAX)) begin
            part = gcci_pkg::PART_BARREL_B;
            row  = VAL_W'(gcci_pkg::BARREL_B_ROW) - t_s;
            copy = barrel_copy;
            crys = barrel_crys;
        end else if (theta < COORD_WIDTH'(gcci_pkg::BARREL_A_END)) begin
            part = gcci_pkg::PART_BARREL_A;
            row  = t_s - VAL_W'(gcci_pkg::BARREL_A_ROW);
            copy = barrel_copy;
            crys = barrel_crys;
        end else if (theta > COORD_WIDTH'(gcci_pkg::FWD_LO) &&
                     theta < COORD_WIDTH'(gcci_pkg::FWD_HI)) begin
            part = gcci_pkg::PART_FWD_ENDCAP;
            row  = (phi >= COORD_WIDTH'(gcci_pkg::FWD_SPLIT)) ?
                   (p_s - VAL_W'(gcci_pkg::FWD_ROW_HI)) :
                   (p_s - VAL_W'(gcci_pkg::FWD_ROW_LO));
            crys = (theta < COORD_WIDTH'(gcci_pkg::FWD_SPLIT)) ?
                   (VAL_W'(gcci_pkg::FWD_CRYS_LO) - t_s) :
                   (VAL_W'(gcci_pkg::FWD_CRYS_HI) - t_s);
        end else if (theta > COORD_WIDTH'(gcci_pkg::FWD_HI) &&
                     theta < COORD_WIDTH'(gcci_pkg::BWD_HI)) begin
            part = gcci_pkg::PART_BWD_ENDCAP;
            row  = quad_row;
            copy = quad_copy;
            crys = quad_crys;
        end else if (theta > COORD_WIDTH'(gcci_pkg::BWD_HI) &&
                     theta < COORD_WIDTH'(gcci_pkg::SHASH_HI)) begin
            part = gcci_pkg::PART_SHASHLYK;
            row  = quad_row;
            copy = quad_copy;
            crys = quad_crys;
        end else if (theta > COORD_WIDTH'(gcci_pkg::SHASH_HI) &&
                     theta < COORD_WIDTH'(gcci_pkg::PROTO_HI)) begin
            part = gcci_pkg::PART_PROTO;
            row  = t_s - VAL_W'(gcci_pkg::PROTO_OFFSET);
            copy = CPY_W'(1);
            crys = p_s - VAL_W'(gcci_pkg::PROTO_OFFSET);
        end
    end

endmodule

>>> design/gcci_pack.sv
// Packs part, row, copy and crystal into the decimal identifier, modulo 2^31.
`timescale 1ns / 1ps

module gcci_pack #(
    parameter int COORD_WIDTH = 10
) (
    input  gcci_pkg::part_t                part,
    input  logic signed [COORD_WIDTH+1:0]  row,
    input  logic [COORD_WIDTH-3:0]         copy,
    input  logic signed [COORD_WIDTH+1:0]  crys,
    output logic [gcci_pkg::ID_W-1:0]      detector_id
);

    localparam int W = gcci_pkg::ID_W;

    logic [W-1:0] part_term;
    logic [W-1:0] row_term;
    logic [W-1:0] copy_term;

    // Constant-weight products, wrapped to the id width
    assign part_term = W'(part) * W'(gcci_pkg::WEIGHT_PART);
    assign row_term  = W'(row)  * W'(gcci_pkg::WEIGHT_ROW);
    assign copy_term = W'(copy) * W'(gcci_pkg::WEIGHT_COPY);

    assign detector_id = part_term + row_term + copy_term + W'(crys);

endmodule

>>> design/grid_coordinate_to_crystal_id.sv
// Top level: three-register pipeline translating grid coordinates to crystal ids.
`timescale 1ns / 1ps

// Translates a calorimeter grid coordinate (theta, phi) into the packed decimal
// crystal id part*1e8 + row*1e6 + copy*1e4 + crystal, plus its unpacked fields;
// theta outside every band gives part 0 and id 0. One beat in gives exactly one
// beat out, in order. Each beat passes an input register, a decode register
// and an output register, in that order, before m_valid offers it. A new beat
// is taken every cycle unless back-pressure from m_ready reaches the input
// stage. Each stage only stalls while the stage after it is full and blocked,
// so bubbles fill in under back-pressure.
module grid_coordinate_to_crystal_id #(
    parameter int COORD_WIDTH = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [COORD_WIDTH-1:0]               s_theta_index,
    input  logic [COORD_WIDTH-1:0]               s_phi_index,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [gcci_pkg::ID_W-1:0]            m_detector_id,
    output logic [gcci_pkg::PART_W-1:0]          m_detector_part,
    output logic signed [gcci_pkg::ROW_W-1:0]    m_row_number,
    output logic [gcci_pkg::COPY_W-1:0]          m_quadrant_copy,
    output logic signed [gcci_pkg::CRYS_W-1:0]   m_crystal_number
);

    localparam int VAL_W = COORD_WIDTH + 2;
    localparam int CPY_W = COORD_WIDTH - 2;

    // Stage valids and readiness
    logic in_valid_reg, mid_valid_reg, out_valid_reg;
    logic in_ready, mid_ready, out_ready;

    // Input stage
    logic [COORD_WIDTH-1:0] theta_reg, phi_reg;

    // Decode stage
    gcci_pkg::part_t          dec_part, part_reg;
    logic signed [VAL_W-1:0]  dec_row, row_reg;
    logic [CPY_W-1:0]         dec_copy, copy_reg;
    logic signed [VAL_W-1:0]  dec_crys, crys_reg;

    // Output stage
    logic [gcci_pkg::ID_W-1:0]          pack_id, id_out_reg;
    logic [gcci_pkg::PART_W-1:0]        part_out_reg;
    logic signed [gcci_pkg::ROW_W-1:0]  row_out_reg;
    logic [gcci_pkg::COPY_W-1:0]        copy_out_reg;
    logic signed [gcci_pkg::CRYS_W-1:0] crys_out_reg;

    assign out_ready = !out_valid_reg || m_ready;
    assign mid_ready = !mid_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg  || mid_ready;
    assign s_ready   = in_ready;

    gcci_decode #(.COORD_WIDTH(COORD_WIDTH)) u_decode (
        .theta (theta_reg),
        .phi   (phi_reg),
        .part  (dec_part),
        .row   (dec_row),
        .copy  (dec_copy),
        .crys  (dec_crys)
    );

    gcci_pack #(.COORD_WIDTH(COORD_WIDTH)) u_pack (
        .part        (part_reg),
        .row         (row_reg),
        .copy        (copy_reg),
        .crys        (crys_reg),
        .detector_id (pack_id)
    );

    // Valid pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready)  in_valid_reg  <= s_valid;
            if (mid_ready) mid_valid_reg <= in_valid_reg;
            if (out_ready) out_valid_reg <= mid_valid_reg;
        end
    end

    // Payload pipeline
    always_ff @(posedge aclk) begin
        if (in_ready && s_valid) begin
            theta_reg <= s_theta_index;
            phi_reg   <= s_phi_index;
        end
        if (mid_ready && in_valid_reg) begin
            part_reg <= dec_part;
            row_reg  <= dec_row;
            copy_reg <= dec_copy;
            crys_reg <= dec_crys;
        end
        if (out_ready && mid_valid_reg) begin
            id_out_reg   <= pack_id;
            part_out_reg <= part_reg;
            row_out_reg  <= row_reg[gcci_pkg::ROW_W-1:0];
            copy_out_reg <= copy_reg[gcci_pkg::COPY_W-1:0];
            crys_out_reg <= crys_reg[gcci_pkg::CRYS_W-1:0];
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_detector_id    = id_out_reg;
    assign m_detector_part  = part_out_reg;
    assign m_row_number     = row_out_reg;
    assign m_quadrant_copy  = copy_out_reg;
    assign m_crystal_number = crys_out_reg;

    // No band means an all-zero id
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_detector_part == gcci_pkg::PART_NONE) |-> (m_detector_id == '0))
        else $error("no-band beat with nonzero id");

    // Barrel crystal is always 1..11
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_detector_part == gcci_pkg::PART_BARREL_A ||
                    m_detector_part == gcci_pkg::PART_BARREL_B)
        |-> (m_crystal_number >= 1 && m_crystal_number <= 11))
        else $error("barrel crystal out of range");

    // Quadrant parts carry copy 1..4
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_detector_part == gcci_pkg::PART_BWD_ENDCAP ||
                    m_detector_part == gcci_pkg::PART_SHASHLYK)
        |-> (m_quadrant_copy >= 1 && m_quadrant_copy <= 4))
        else $error("quadrant copy out of range");

    // Forward endcap has copy 0, prototype copy 1
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_detector_part == gcci_pkg::PART_FWD_ENDCAP) |-> (m_quadrant_copy == 0))
        else $error("forward endcap copy nonzero");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_detector_part == gcci_pkg::PART_PROTO) |-> (m_quadrant_copy == 1))
        else $error("prototype copy not one");

    // An accepted beat occupies the input stage next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted beat lost at input stage");

endmodule
